FILE: sv/epe_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// epe_pkg: shared types and constants of the erasure parity encoder
// Payload structs, configuration register indexes, pipeline control and
// the GF(2^8) shift-and-reduce multiply used by every source lane.
// ---------------------------------------------------------------------------
package epe_pkg;

    // Parameter defaults and the lane counts fixed by the payload fields.
    localparam int MAX_SOURCES_DEF  = 8;
    localparam int MAX_PARITIES_DEF = 4;
    localparam int SRC_FIELD_LANES  = 8;
    localparam int PAR_FIELD_LANES  = 4;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    typedef logic [CFG_INDEX_W-1:0] cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_COEF_ROW0    = 3'd0;
    localparam cfg_idx_t CFG_COEF_ROW1    = 3'd1;
    localparam cfg_idx_t CFG_COEF_ROW2    = 3'd2;
    localparam cfg_idx_t CFG_COEF_ROW3    = 3'd3;
    localparam cfg_idx_t CFG_SOURCE_COUNT = 3'd4;
    localparam cfg_idx_t CFG_PARITY_COUNT = 3'd5;
    localparam cfg_idx_t CFG_FIELD_POLY   = 3'd6;

    // Register reset values.
    localparam logic [3:0] SOURCE_COUNT_RST = 4'd8;
    localparam logic [2:0] PARITY_COUNT_RST = 3'd4;
    localparam logic [7:0] FIELD_POLY_RST   = 8'h1D;

    typedef struct packed {
        logic [8*SRC_FIELD_LANES-1:0] source_bytes;
        logic                         end_of_symbol;
    } src_req_t;

    typedef struct packed {
        logic [8*PAR_FIELD_LANES-1:0] parity_bytes;
        logic                         end_of_symbol_out;
    } par_req_t;

    // Load enables of the two pipeline stages.
    typedef struct packed {
        logic s1_load;
        logic s2_load;
    } pipe_ctrl_t;

    // GF(2^8) product of a and b, reduced by x^8 + poly.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] poly);
        logic [7:0] acc;
        logic [7:0] sh;
        logic       carry;
        acc = 8'h00;
        sh  = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ sh;
            end
            carry = sh[7];
            sh    = {sh[6:0], 1'b0};
            if (carry)
            begin
                sh = sh ^ poly;
            end
        end
        return acc;
    endfunction

endpackage
`default_nettype wire

FILE: sv/erasure_parity_encode_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// erasure_parity_encode_unit: GF(2^8) matrix erasure-code parity encoder
// Pipeline: an accepted request passes the stage one product register and
// then the output register, from which it is offered on the output.
// Throughput: one byte position per cycle. Stage one refills in the cycle in
// which it hands on to the output register; a stalled output holds both
// stages once both are full.
// Reset: rst_n clears the valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
module erasure_parity_encode_unit
    import epe_pkg::*;
#(
    parameter int MAX_SOURCES  = MAX_SOURCES_DEF,
    parameter int MAX_PARITIES = MAX_PARITIES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire cfg_idx_t               cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   src_valid,
    output logic                        src_ready,
    input  wire src_req_t               src_data,
    output logic                        par_valid,
    input  wire logic                   par_ready,
    output par_req_t                    par_data
);

    localparam int SRC_LANES = (MAX_SOURCES < SRC_FIELD_LANES) ? MAX_SOURCES
                                                               : SRC_FIELD_LANES;
    localparam int PAR_LANES = (MAX_PARITIES < PAR_FIELD_LANES) ? MAX_PARITIES
                                                                : PAR_FIELD_LANES;

    logic [PAR_LANES-1:0][CFG_DATA_W-1:0] coef_reg;
    logic [3:0]                           source_count_reg;
    logic [2:0]                           parity_count_reg;
    logic [7:0]                           field_poly_reg;

    logic                                 s1_valid_reg;
    logic                                 s1_eos_reg;
    logic                                 out_valid_reg;
    pipe_ctrl_t                           ctrl;

    logic [SRC_LANES-1:0]                 src_active;
    logic [PAR_LANES-1:0]                 par_active;
    logic [PAR_LANES-1:0][SRC_LANES-1:0][7:0] products;
    logic [8*PAR_FIELD_LANES-1:0]         par_byte_mask;

    // Coefficient rows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            for (int j = 0; j < PAR_LANES; j++)
            begin
                if (cfg_we && (cfg_index == cfg_idx_t'(int'(CFG_COEF_ROW0) + j)))
                begin
                    coef_reg[j] <= cfg_data;
                end
            end
        end
    end

    // Count and polynomial registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_count_reg <= SOURCE_COUNT_RST;
            parity_count_reg <= PARITY_COUNT_RST;
            field_poly_reg   <= FIELD_POLY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOURCE_COUNT: source_count_reg <= cfg_data[3:0];
                CFG_PARITY_COUNT: parity_count_reg <= cfg_data[2:0];
                CFG_FIELD_POLY:   field_poly_reg   <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Active lanes; the lane count bounds the configured counts.
    always_comb
    begin
        for (int i = 0; i < SRC_LANES; i++)
        begin
            src_active[i] = (source_count_reg > 4'(i));
        end
        par_byte_mask = '0;
        for (int j = 0; j < PAR_LANES; j++)
        begin
            par_active[j] = (parity_count_reg > 3'(j));
            par_byte_mask[8*j +: 8] = {8{par_active[j]}};
        end
    end

    // Pipeline handshake: each stage loads when it is free or draining.
    always_comb
    begin
        ctrl.s2_load = s1_valid_reg && (!out_valid_reg || par_ready);
        src_ready    = !s1_valid_reg || ctrl.s2_load;
        ctrl.s1_load = src_valid && src_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (src_ready)
            begin
                s1_valid_reg <= src_valid;
            end
            if (!out_valid_reg || par_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Stage one carries the end-of-symbol flag beside the products.
    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            s1_eos_reg <= src_data.end_of_symbol;
        end
    end

    // One lane per parity.
    for (genvar j = 0; j < PAR_LANES; j++)
    begin : g_lane
        epe_parity_lane #(
            .SRC_LANES (SRC_LANES)
        ) u_lane (
            .clk          (clk),
            .ctrl         (ctrl),
            .coef_row     (coef_reg[j]),
            .source_bytes (src_data.source_bytes),
            .src_active   (src_active),
            .field_poly   (field_poly_reg),
            .products     (products[j])
        );
    end

    epe_merge #(
        .SRC_LANES (SRC_LANES),
        .PAR_LANES (PAR_LANES)
    ) u_merge (
        .clk        (clk),
        .ctrl       (ctrl),
        .products   (products),
        .par_active (par_active),
        .s1_eos     (s1_eos_reg),
        .result     (par_data)
    );

    assign par_valid = out_valid_reg;

    // Parities not in use always read zero.
    a_unused_parity_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((par_data.parity_bytes & ~par_byte_mask) == '0))
        else $error("unused parity byte is not zero");

    // An accepted request always occupies stage one next cycle.
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && src_ready) |=> s1_valid_reg)
        else $error("accepted request lost in stage one");

    // A request in stage one moves on whenever the output stage is free.
    a_s1_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (!out_valid_reg || par_ready)) |=> out_valid_reg)
        else $error("stage one request did not reach the output");

    // With both stages full and the output stalled, no request is taken.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !par_ready) |-> !src_ready)
        else $error("request taken while pipeline is full");

endmodule
`default_nettype wire

FILE: sv/epe_parity_lane.sv
`default_nettype none
// ---------------------------------------------------------------------------
// epe_parity_lane: source products for one parity
// Multiplies every source byte by its coefficient of this parity's row in
// parallel and registers the products; inactive sources give zero.
// ---------------------------------------------------------------------------
module epe_parity_lane
    import epe_pkg::*;
#(
    parameter int SRC_LANES = MAX_SOURCES_DEF
)
(
    input  wire logic                           clk,
    input  wire pipe_ctrl_t                     ctrl,
    input  wire logic [8*SRC_FIELD_LANES-1:0]   coef_row,
    input  wire logic [8*SRC_FIELD_LANES-1:0]   source_bytes,
    input  wire logic [SRC_LANES-1:0]           src_active,
    input  wire logic [7:0]                     field_poly,
    output logic      [SRC_LANES-1:0][7:0]      products
);

    logic [SRC_LANES-1:0][7:0] prod_reg;
    logic [SRC_LANES-1:0][7:0] prod_next;

    // One multiplier for each source lane.
    always_comb
    begin
        for (int i = 0; i < SRC_LANES; i++)
        begin
            if (src_active[i])
            begin
                prod_next[i] = gf_mul(source_bytes[8*i +: 8], coef_row[8*i +: 8],
                                      field_poly);
            end
            else
            begin
                prod_next[i] = 8'h00;
            end
        end
    end

    // Stage one product register.
    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign products = prod_reg;

endmodule
`default_nettype wire

FILE: sv/epe_merge.sv
`default_nettype none
// ---------------------------------------------------------------------------
// epe_merge: parity merge and output register
// XORs the products of each parity lane, zeroes parities not in use and
// holds the finished result request for the output channel.
// ---------------------------------------------------------------------------
module epe_merge
    import epe_pkg::*;
#(
    parameter int SRC_LANES = MAX_SOURCES_DEF,
    parameter int PAR_LANES = MAX_PARITIES_DEF
)
(
    input  wire logic                                 clk,
    input  wire pipe_ctrl_t                           ctrl,
    input  wire logic [PAR_LANES-1:0][SRC_LANES-1:0][7:0] products,
    input  wire logic [PAR_LANES-1:0]                 par_active,
    input  wire logic                                 s1_eos,
    output par_req_t                                  result
);

    par_req_t out_reg;
    par_req_t out_next;

    // XOR reduction over the sources of each parity.
    always_comb
    begin
        logic [7:0] acc;
        out_next = '0;
        for (int j = 0; j < PAR_LANES; j++)
        begin
            acc = 8'h00;
            for (int i = 0; i < SRC_LANES; i++)
            begin
                acc = acc ^ products[j][i];
            end
            if (par_active[j])
            begin
                out_next.parity_bytes[8*j +: 8] = acc;
            end
        end
        out_next.end_of_symbol_out = s1_eos;
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (ctrl.s2_load)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule
`default_nettype wire
